>>> hdl/idempotent_order_send_queue_assert.svh
// Assertion macros for the order send queue
`ifndef IDEMPOTENT_ORDER_SEND_QUEUE_ASSERT_SVH
`define IDEMPOTENT_ORDER_SEND_QUEUE_ASSERT_SVH
// implication checked every clock outside reset
`define IOSQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define IOSQ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> hdl/iosq_pkg.sv
// Package: constants and types for the order send queue
package iosq_pkg;
    localparam int QUEUE_DEPTH = 4;
    localparam int ID_COUNT    = 16;
    localparam int QW          = $clog2(QUEUE_DEPTH + 1);
    localparam int QIW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int IDW         = $clog2(ID_COUNT + 1);

    localparam logic [7:0] FRAME_MARK = 8'hA5;
    localparam logic [2:0] FRAME_LEN  = 3'd5;

    localparam logic [2:0] M_CONNECT = 3'd0;
    localparam logic [2:0] M_ENQUEUE = 3'd1;
    localparam logic [2:0] M_DISCON  = 3'd2;
    localparam logic [2:0] M_PUMP    = 3'd3;
    localparam logic [2:0] M_ACK     = 3'd4;
    localparam logic [2:0] M_RESOLVE = 3'd5;
    localparam logic [2:0] M_POP     = 3'd6;

    localparam logic [2:0] PH_QUEUED  = 3'd0;
    localparam logic [2:0] PH_SENDING = 3'd1;
    localparam logic [2:0] PH_AWAIT   = 3'd2;
    localparam logic [2:0] PH_UNKNOWN = 3'd3;
    localparam logic [2:0] PH_FINAL   = 3'd4;
    localparam logic [2:0] PH_EMPTY   = 3'd5;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ONE   = 3'd1;
    localparam logic [2:0] ST_TWO   = 3'd2;
    localparam logic [2:0] ST_THREE = 3'd3;
    localparam logic [2:0] ST_FOUR  = 3'd4;

    localparam logic [1:0] CFG_SESSION = 2'd0;
    localparam logic [1:0] CFG_QLIMIT  = 2'd1;
    localparam logic [1:0] CFG_GLIMIT  = 2'd2;

    typedef struct packed {
        logic [4:0] id;
        logic [3:0] qty;
        logic [2:0] offset;
        logic [2:0] phase;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic       exec;
        logic       set_frozen;
        logic       set_conn;
        logic       clr_conn;
        logic       gen_inc;
        logic       push;
        logic       pop;
        logic       front_wr;
        t_slot      front_new;
        logic       rcpt_wr;
        logic [3:0] rcpt_qty;
        logic       rcpt_ver;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       frozen;
        logic       connected;
        logic [4:0] gen;
        logic [QW-1:0] size;
        t_slot      front;
        logic       used;
        logic       rc_valid;
        logic [3:0] rc_qty;
        logic       rc_ver;
        logic       fr_valid;
        logic [3:0] fr_qty;
        logic       fr_ver;
    } t_stat;
endpackage

>>> hdl/iosq_datapath.sv
// Datapath: queue, id bitmap, receipt table, link flags
module iosq_datapath import iosq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [4:0] i_req_id,
    input  logic [3:0] i_quantity,
    output t_stat      o_stat
);
    t_slot         r_q [QUEUE_DEPTH];
    logic [QW-1:0] r_size;
    logic [ID_COUNT:1] r_used;
    logic [ID_COUNT:1] r_rv;
    logic [3:0]    r_rq [ID_COUNT+1];
    logic          r_rver [ID_COUNT+1];
    logic [4:0]    r_gen;
    logic          r_conn;
    logic          r_frozen;
    logic          id_ok, fid_ok;
    logic [IDW-1:0] idx, fidx;

    assign id_ok  = (i_req_id != 5'd0) && ({{(32-5){1'b0}}, i_req_id} <= ID_COUNT);
    assign fid_ok = (r_q[0].id != 5'd0) && ({{(32-5){1'b0}}, r_q[0].id} <= ID_COUNT);
    assign idx    = IDW'(i_req_id);
    assign fidx   = IDW'(r_q[0].id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= '0;
            r_used   <= '0;
            r_rv     <= '0;
            r_gen    <= '0;
            r_conn   <= 1'b0;
            r_frozen <= 1'b0;
        end else if (i_cmd.exec) begin
            if (i_cmd.set_frozen) r_frozen <= 1'b1;
            if (i_cmd.set_conn) r_conn <= 1'b1;
            if (i_cmd.clr_conn) r_conn <= 1'b0;
            if (i_cmd.gen_inc) r_gen <= r_gen + 5'd1;
            if (i_cmd.push) begin
                r_used[idx] <= 1'b1;
                r_size      <= r_size + QW'(1);
            end
            if (i_cmd.pop) r_size <= r_size - QW'(1);
            if (i_cmd.rcpt_wr && fid_ok) r_rv[fidx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (i_cmd.push) begin
                r_q[QIW'(r_size)] <= '{id: i_req_id, qty: i_quantity,
                                       offset: 3'd0, phase: PH_QUEUED};
            end
            if (i_cmd.front_wr) r_q[0] <= i_cmd.front_new;
            if (i_cmd.pop) begin
                for (int k = 0; k < QUEUE_DEPTH - 1; k++) r_q[k] <= r_q[k+1];
            end
            if (i_cmd.rcpt_wr && fid_ok) begin
                r_rq[fidx]   <= i_cmd.rcpt_qty;
                r_rver[fidx] <= i_cmd.rcpt_ver;
            end
        end
    end

    always_comb begin
        o_stat.frozen    = r_frozen;
        o_stat.connected = r_conn;
        o_stat.gen       = r_gen;
        o_stat.size      = r_size;
        o_stat.front     = r_q[0];
        o_stat.used      = id_ok ? r_used[idx] : 1'b0;
        o_stat.rc_valid  = id_ok ? r_rv[idx] : 1'b0;
        o_stat.rc_qty    = r_rq[idx];
        o_stat.rc_ver    = r_rver[idx];
        o_stat.fr_valid  = fid_ok ? r_rv[fidx] : 1'b0;
        o_stat.fr_qty    = r_rq[fidx];
        o_stat.fr_ver    = r_rver[fidx];
    end
endmodule

>>> hdl/iosq_ctrl.sv
// Controller: request decode, state machine and result register
module iosq_ctrl import iosq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_session,
    input  logic [4:0]  i_req_id,
    input  logic [3:0]  i_quantity,
    input  logic [1:0]  i_verdict,
    input  logic [1:0]  i_evidence_kind,
    input  logic [4:0]  i_link_generation,
    input  logic [2:0]  i_allowance,
    input  logic        i_transport_fatal,
    input  logic [7:0]  i_sess_code,
    input  logic [3:0]  i_qlimit,
    input  logic [4:0]  i_glimit,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_sent,
    output logic        o_rvalid,
    output logic [4:0]  o_rid,
    output logic [3:0]  o_rqty,
    output logic        o_rver
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SHOW = 2'd1;

    logic [1:0] r_state, n_state;
    logic [2:0] r_status, n_status;
    logic [2:0] r_sent, n_sent;
    logic       r_rv, n_rv;
    logic [4:0] r_rid, n_rid;
    logic [3:0] r_rqty, n_rqty;
    logic       r_rver, n_rver;
    logic       accept;
    t_cmd       c;
    t_slot      f;
    logic       nonempty, gen_ok, id_ok;
    logic [2:0] room, snt, noff;

    // live state feeds the result fields, so nothing is taken while a result waits
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state != S_IDLE);

    assign f        = i_stat.front;
    assign nonempty = (i_stat.size != '0);
    assign gen_ok   = (i_link_generation == i_stat.gen);
    assign id_ok    = (i_req_id != 5'd0) && ({{(32-5){1'b0}}, i_req_id} <= ID_COUNT);
    assign room     = (f.offset < FRAME_LEN) ? FRAME_LEN - f.offset : 3'd0;
    assign snt      = (i_allowance < room) ? i_allowance : room;
    assign noff     = f.offset + snt;

    always_comb begin
        c = '0;
        c.exec = accept;
        c.front_new = f;
        n_status = ST_ONE;
        n_sent = 3'd0;
        n_rv = 1'b0; n_rid = 5'd0; n_rqty = 4'd0; n_rver = 1'b0;
        case (i_mode)
            M_CONNECT: begin
                if (!i_stat.frozen && !i_stat.connected) begin
                    if (i_session != i_sess_code || i_stat.gen >= i_glimit
                        || i_stat.gen >= 5'd31) begin
                        c.set_frozen = 1'b1;
                    end else begin
                        c.gen_inc = 1'b1; c.set_conn = 1'b1; n_status = ST_OK;
                    end
                end
            end
            M_ENQUEUE: begin
                if (i_stat.frozen) n_status = ST_FOUR;
                else if (!id_ok || i_quantity == 4'd0 || i_quantity > i_qlimit)
                    n_status = ST_ONE;
                else if (i_stat.used) n_status = ST_TWO;
                else if ({{(32-QW){1'b0}}, i_stat.size} >= QUEUE_DEPTH)
                    n_status = ST_THREE;
                else begin
                    c.push = 1'b1; n_status = ST_OK;
                end
            end
            M_DISCON: begin
                if (i_stat.connected && gen_ok) begin
                    c.clr_conn = 1'b1; n_status = ST_OK;
                    if (nonempty && f.phase != PH_FINAL && f.offset != 3'd0) begin
                        c.front_wr = 1'b1; c.front_new.phase = PH_UNKNOWN;
                    end
                end
            end
            M_PUMP: begin
                if (i_stat.connected && !i_stat.frozen && nonempty && gen_ok
                    && (f.phase == PH_QUEUED || f.phase == PH_SENDING)) begin
                    n_status = ST_OK;
                    if (i_transport_fatal) begin
                        c.clr_conn = 1'b1;
                        if (f.offset != 3'd0) begin
                            c.front_wr = 1'b1; c.front_new.phase = PH_UNKNOWN;
                        end
                    end else begin
                        n_sent = snt;
                        c.front_wr = 1'b1;
                        c.front_new.offset = noff;
                        c.front_new.phase = (noff == FRAME_LEN) ? PH_AWAIT :
                            (noff == 3'd0) ? PH_QUEUED : PH_SENDING;
                    end
                end
            end
            M_ACK: begin
                if (!i_stat.connected || !gen_ok) n_status = ST_TWO;
                else if (i_stat.frozen) n_status = ST_THREE;
                else if (i_session != i_sess_code || i_verdict > 2'd1) begin
                    c.set_frozen = 1'b1; n_status = ST_FOUR;
                end else if (!id_ok) n_status = ST_THREE;
                else if (i_stat.rc_valid) begin
                    if (i_stat.rc_qty == i_quantity && i_stat.rc_ver == i_verdict[0])
                        n_status = ST_ONE;
                    else begin
                        c.set_frozen = 1'b1; n_status = ST_FOUR;
                    end
                end else if (!nonempty || f.id != i_req_id || f.phase != PH_AWAIT)
                    n_status = ST_THREE;
                else if (f.qty != i_quantity) begin
                    c.set_frozen = 1'b1; n_status = ST_FOUR;
                end else begin
                    c.rcpt_wr = 1'b1; c.rcpt_qty = i_quantity; c.rcpt_ver = i_verdict[0];
                    c.front_wr = 1'b1; c.front_new.phase = PH_FINAL;
                    n_status = ST_OK;
                end
            end
            M_RESOLVE: begin
                if (i_stat.connected && !i_stat.frozen && gen_ok && nonempty
                    && f.phase == PH_UNKNOWN) begin
                    if (i_session != i_sess_code || i_req_id != f.id
                        || i_quantity != f.qty || i_verdict > 2'd1
                        || i_evidence_kind > 2'd2) begin
                        c.set_frozen = 1'b1;
                    end else if (i_evidence_kind == 2'd0) begin
                        c.rcpt_wr = 1'b1; c.rcpt_qty = i_quantity;
                        c.rcpt_ver = i_verdict[0];
                        c.front_wr = 1'b1; c.front_new.phase = PH_FINAL;
                        n_status = ST_OK;
                    end else if (i_evidence_kind == 2'd2) begin
                        c.front_wr = 1'b1; c.front_new.offset = 3'd0;
                        c.front_new.phase = PH_QUEUED;
                        n_status = ST_OK;
                    end
                end
            end
            M_POP: begin
                if (nonempty && f.phase == PH_FINAL) begin
                    c.pop = 1'b1;
                    if (i_stat.fr_valid) begin
                        n_rv = 1'b1; n_rid = f.id; n_rqty = i_stat.fr_qty;
                        n_rver = i_stat.fr_ver; n_status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        o_cmd = c;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_SHOW;
            S_SHOW:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status; r_sent <= n_sent; r_rv <= n_rv;
            r_rid <= n_rid; r_rqty <= n_rqty; r_rver <= n_rver;
        end
    end

    assign o_status = r_status;
    assign o_sent   = r_sent;
    assign o_rvalid = r_rv;
    assign o_rid    = r_rid;
    assign o_rqty   = r_rqty;
    assign o_rver   = r_rver;
endmodule

>>> hdl/idempotent_order_send_queue.sv
// Top level: order send queue with idempotent acknowledgement
// Usage:
//  Requests enter on i_in_valid/o_in_stall with one port per field; results
//  leave on o_out_valid/i_out_stall. One result per request.
//  Each request is executed in the cycle it is accepted; its result is held
//  in an output register and appears in the following cycle.
//  Input is stalled while a result is shown, so a new request is taken only
//  once the receiver has taken the previous result.
//  The front fields (phase, offset, frame) show the live queue state, which
//  cannot move while a result waits.
//  Configuration: i_cfg_valid/o_cfg_ready with index and data, always ready;
//  write only while idle. Index 0 session code, 1 quantity limit,
//  2 generation limit; other indexes ignored.
//  Synchronous active-low reset empties the queue, clears ids, receipts,
//  generation and flags, and loads register defaults 7, 8 and 16.
module idempotent_order_send_queue import iosq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_session,
    input  logic [4:0]  i_req_id,
    input  logic [3:0]  i_quantity,
    input  logic [1:0]  i_verdict,
    input  logic [1:0]  i_evidence_kind,
    input  logic [4:0]  i_link_generation,
    input  logic [2:0]  i_allowance,
    input  logic        i_transport_fatal,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_frozen,
    output logic [4:0]  o_generation_now,
    output logic [2:0]  o_queue_count,
    output logic [2:0]  o_front_phase,
    output logic [2:0]  o_front_offset,
    output logic [2:0]  o_sent_count,
    output logic [39:0] o_frame_bytes,
    output logic        o_result_valid,
    output logic [4:0]  o_result_id,
    output logic [3:0]  o_result_quantity,
    output logic        o_result_verdict
);
`include "idempotent_order_send_queue_assert.svh"
    logic [7:0] r_sess;
    logic [3:0] r_qlim;
    logic [4:0] r_glim;
    t_cmd       cmd;
    t_stat      stat;
    logic       ne;
    logic [7:0] b2, b3;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess <= 8'd7; r_qlim <= 4'd8; r_glim <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SESSION: r_sess <= i_cfg_data;
                CFG_QLIMIT:  r_qlim <= i_cfg_data[3:0];
                CFG_GLIMIT:  r_glim <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    iosq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_mode, .i_session,
        .i_req_id, .i_quantity, .i_verdict, .i_evidence_kind,
        .i_link_generation, .i_allowance, .i_transport_fatal,
        .i_sess_code(r_sess), .i_qlimit(r_qlim), .i_glimit(r_glim),
        .i_stat(stat), .o_cmd(cmd), .o_out_valid, .i_out_stall,
        .o_status, .o_sent(o_sent_count), .o_rvalid(o_result_valid),
        .o_rid(o_result_id), .o_rqty(o_result_quantity), .o_rver(o_result_verdict)
    );

    iosq_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_req_id, .i_quantity, .o_stat(stat)
    );

    assign ne = (stat.size != '0);
    assign b2 = {3'd0, stat.front.id};
    assign b3 = {4'd0, stat.front.qty};
    assign o_frozen         = stat.frozen;
    assign o_generation_now = stat.gen;
    assign o_queue_count    = 3'(stat.size);
    assign o_front_phase    = ne ? stat.front.phase : PH_EMPTY;
    assign o_front_offset   = ne ? stat.front.offset : 3'd0;
    assign o_frame_bytes    = ne ? {FRAME_MARK, r_sess, b2, b3,
                                    FRAME_MARK ^ r_sess ^ b2 ^ b3} : 40'd0;

    `IOSQ_ASSERT_IMP(a_gen_limit, i_clk, i_rst_n, 1'b1, stat.gen <= 5'd31)
    `IOSQ_ASSERT_NXT(a_frozen_sticky, i_clk, i_rst_n, stat.frozen, stat.frozen)
    `IOSQ_ASSERT_IMP(a_size_max, i_clk, i_rst_n, 1'b1,
        {{(32-QW){1'b0}}, stat.size} <= QUEUE_DEPTH)
    `IOSQ_ASSERT_IMP(a_pop_result, i_clk, i_rst_n, o_out_valid && o_result_valid,
        o_status == ST_OK)
endmodule

>>> sim/order_queue_checker.sv
// Checker for the order send queue: predicts each result and compares it with the block
`timescale 1ns / 1ps
module order_queue_checker import iosq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_session,
    input  logic [4:0]  i_req_id,
    input  logic [3:0]  i_quantity,
    input  logic [1:0]  i_verdict,
    input  logic [1:0]  i_evidence_kind,
    input  logic [4:0]  i_link_generation,
    input  logic [2:0]  i_allowance,
    input  logic        i_transport_fatal,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic        i_frozen,
    input  logic [4:0]  i_generation_now,
    input  logic [2:0]  i_queue_count,
    input  logic [2:0]  i_front_phase,
    input  logic [2:0]  i_front_offset,
    input  logic [2:0]  i_sent_count,
    input  logic [39:0] i_frame_bytes,
    input  logic        i_result_valid,
    input  logic [4:0]  i_result_id,
    input  logic [3:0]  i_result_quantity,
    input  logic        i_result_verdict,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_receipts
);
    typedef struct packed {
        logic [2:0]  status;
        logic        frozen;
        logic [4:0]  gen;
        logic [2:0]  count;
        logic [2:0]  phase;
        logic [2:0]  offset;
        logic [2:0]  sent;
        logic [39:0] frame;
        logic        rv;
        logic [4:0]  rid;
        logic [3:0]  rqty;
        logic        rver;
    } t_status_word;

    t_status_word status_due[$];

    logic [7:0] sess_code;
    logic [3:0] qty_limit;
    logic [4:0] gen_limit;
    t_slot      slots [QUEUE_DEPTH];
    int         depth;
    logic       id_taken [ID_COUNT+1];
    logic       rc_valid [ID_COUNT+1];
    logic [3:0] rc_qty   [ID_COUNT+1];
    logic       rc_ver   [ID_COUNT+1];
    logic [4:0] gen_count;
    logic       linked;
    logic       frozen_now;
    int         fails;
    int         checked;
    int         receipts;

    assign o_fail_count = fails;
    assign o_pending    = status_due.size();
    assign o_checked    = checked;
    assign o_receipts   = receipts;

    function automatic logic id_valid(logic [4:0] id);
        return id != 0 && id <= ID_COUNT;
    endfunction

    task automatic drop_link();
        linked = 1'b0;
        if (depth != 0 && slots[0].phase != PH_FINAL && slots[0].offset != 0)
            slots[0].phase = PH_UNKNOWN;
    endtask

    task automatic complete_front(logic [3:0] qty, logic ver);
        if (id_valid(slots[0].id)) begin
            rc_valid[slots[0].id] = 1'b1;
            rc_qty[slots[0].id]   = qty;
            rc_ver[slots[0].id]   = ver;
        end
        slots[0].phase = PH_FINAL;
    endtask

    task automatic apply_request(output t_status_word r);
        logic [2:0] st;
        logic [2:0] sent;
        logic [2:0] room;
        logic       rv;
        logic [4:0] rid;
        logic [3:0] rqty;
        logic       rver;
        logic [7:0] b2;
        logic [7:0] b3;
        st = ST_ONE; sent = 0; rv = 0; rid = 0; rqty = 0; rver = 0;
        case (i_mode)
            M_CONNECT: begin
                if (!frozen_now && !linked) begin
                    if (i_session != sess_code || gen_count >= gen_limit || gen_count >= 31)
                        frozen_now = 1'b1;
                    else begin
                        gen_count++;
                        linked = 1'b1;
                        st = ST_OK;
                    end
                end
            end
            M_ENQUEUE: begin
                if (frozen_now) st = ST_FOUR;
                else if (!id_valid(i_req_id) || i_quantity == 0 || i_quantity > qty_limit)
                    st = ST_ONE;
                else if (id_taken[i_req_id]) st = ST_TWO;
                else if (depth >= QUEUE_DEPTH) st = ST_THREE;
                else begin
                    slots[depth] = '{id: i_req_id, qty: i_quantity, offset: 0, phase: PH_QUEUED};
                    depth++;
                    id_taken[i_req_id] = 1'b1;
                    st = ST_OK;
                end
            end
            M_DISCON: begin
                if (linked && i_link_generation == gen_count) begin
                    drop_link();
                    st = ST_OK;
                end
            end
            M_PUMP: begin
                if (linked && !frozen_now && depth != 0 && i_link_generation == gen_count &&
                    (slots[0].phase == PH_QUEUED || slots[0].phase == PH_SENDING)) begin
                    st = ST_OK;
                    if (i_transport_fatal) drop_link();
                    else begin
                        room = (slots[0].offset < FRAME_LEN) ? FRAME_LEN - slots[0].offset : 0;
                        sent = (i_allowance < room) ? i_allowance : room;
                        slots[0].offset += sent;
                        slots[0].phase = (slots[0].offset == FRAME_LEN) ? PH_AWAIT :
                                         (slots[0].offset == 0) ? PH_QUEUED : PH_SENDING;
                    end
                end
            end
            M_ACK: begin
                if (!linked || i_link_generation != gen_count) st = ST_TWO;
                else if (frozen_now) st = ST_THREE;
                else if (i_session != sess_code || i_verdict > 1) begin
                    frozen_now = 1'b1; st = ST_FOUR;
                end else if (!id_valid(i_req_id)) st = ST_THREE;
                else if (rc_valid[i_req_id]) begin
                    if (rc_qty[i_req_id] == i_quantity && rc_ver[i_req_id] == i_verdict[0])
                        st = ST_ONE;
                    else begin
                        frozen_now = 1'b1; st = ST_FOUR;
                    end
                end else if (depth == 0 || slots[0].id != i_req_id || slots[0].phase != PH_AWAIT)
                    st = ST_THREE;
                else if (slots[0].qty != i_quantity) begin
                    frozen_now = 1'b1; st = ST_FOUR;
                end else begin
                    complete_front(i_quantity, i_verdict[0]);
                    st = ST_OK;
                end
            end
            M_RESOLVE: begin
                if (linked && !frozen_now && i_link_generation == gen_count && depth != 0 &&
                    slots[0].phase == PH_UNKNOWN) begin
                    if (i_session != sess_code || i_req_id != slots[0].id ||
                        i_quantity != slots[0].qty || i_verdict > 1 || i_evidence_kind > 2)
                        frozen_now = 1'b1;
                    else if (i_evidence_kind == 0) begin
                        complete_front(i_quantity, i_verdict[0]);
                        st = ST_OK;
                    end else if (i_evidence_kind == 2) begin
                        slots[0].offset = 0;
                        slots[0].phase  = PH_QUEUED;
                        st = ST_OK;
                    end
                end
            end
            M_POP: begin
                if (depth != 0 && slots[0].phase == PH_FINAL) begin
                    rid = slots[0].id;
                    if (id_valid(rid)) begin
                        rv = rc_valid[rid]; rqty = rc_qty[rid]; rver = rc_ver[rid];
                    end
                    if (!rv) begin
                        rid = 0; rqty = 0; rver = 0;
                    end
                    for (int i = 1; i < depth; i++) slots[i-1] = slots[i];
                    depth--;
                    slots[depth] = '0;
                    st = rv ? ST_OK : ST_ONE;
                end
            end
            default: ;
        endcase
        r = '0;
        r.status = st;
        r.frozen = frozen_now;
        r.gen    = gen_count;
        r.count  = depth[2:0];
        r.sent   = sent;
        r.rv = rv; r.rid = rid; r.rqty = rqty; r.rver = rver;
        if (depth == 0) r.phase = PH_EMPTY;
        else begin
            r.phase  = slots[0].phase;
            r.offset = slots[0].offset;
            b2 = {3'b0, slots[0].id};
            b3 = {4'b0, slots[0].qty};
            r.frame = {FRAME_MARK, sess_code, b2, b3, FRAME_MARK ^ sess_code ^ b2 ^ b3};
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %0t: %s got %0h want %0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic compare_status(t_status_word w);
        if (i_status != w.status) report("status", i_status, w.status);
        if (i_frozen != w.frozen) report("frozen", i_frozen, w.frozen);
        if (i_generation_now != w.gen) report("generation", i_generation_now, w.gen);
        if (i_queue_count != w.count) report("queue_count", i_queue_count, w.count);
        if (i_front_phase != w.phase) report("front_phase", i_front_phase, w.phase);
        if (i_front_offset != w.offset) report("front_offset", i_front_offset, w.offset);
        if (i_sent_count != w.sent) report("sent_count", i_sent_count, w.sent);
        if (i_frame_bytes != w.frame) report("frame_bytes", i_frame_bytes, w.frame);
        if (i_result_valid != w.rv) report("result_valid", i_result_valid, w.rv);
        if (i_result_id != w.rid) report("result_id", i_result_id, w.rid);
        if (i_result_quantity != w.rqty) report("result_quantity", i_result_quantity, w.rqty);
        if (i_result_verdict != w.rver) report("result_verdict", i_result_verdict, w.rver);
    endtask

    initial begin
        fails = 0; checked = 0; receipts = 0;
    end

    always @(posedge i_clk) begin
        t_status_word w;
        if (!i_rst_n) begin
            sess_code = 8'd7; qty_limit = 4'd8; gen_limit = 5'd16;
            for (int i = 0; i < QUEUE_DEPTH; i++) slots[i] = '0;
            for (int i = 0; i <= ID_COUNT; i++) begin
                id_taken[i] = 0; rc_valid[i] = 0; rc_qty[i] = 0; rc_ver[i] = 0;
            end
            depth = 0; gen_count = 0; linked = 0; frozen_now = 0;
            status_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    $display("mismatch %0t: result with no request outstanding", $realtime);
                    fails++;
                end else begin
                    w = status_due.pop_front();
                    compare_status(w);
                    checked++;
                    if (w.rv) receipts++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SESSION: sess_code = i_cfg_data;
                    CFG_QLIMIT:  qty_limit = i_cfg_data[3:0];
                    CFG_GLIMIT:  gen_limit = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(w);
                status_due.push_back(w);
            end
        end
    end
endmodule

>>> sim/testbench.sv
// Testbench top: drives requests and register writes into the order send queue
`timescale 1ns / 1ps
module testbench;
    import iosq_pkg::*;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] sess;
        logic [4:0] id;
        logic [3:0] qty;
        logic [1:0] ver;
        logic [1:0] kind;
        logic [4:0] gen;
        logic [2:0] allow;
        logic       fatal;
    } t_request;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [7:0]  i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    t_request    req = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [2:0]  o_status;
    logic        o_frozen;
    logic [4:0]  o_generation_now;
    logic [2:0]  o_queue_count;
    logic [2:0]  o_front_phase;
    logic [2:0]  o_front_offset;
    logic [2:0]  o_sent_count;
    logic [39:0] o_frame_bytes;
    logic        o_result_valid;
    logic [4:0]  o_result_id;
    logic [3:0]  o_result_quantity;
    logic        o_result_verdict;
    int          fail_count, pending, checked, receipts;
    logic        calm = 0;
    logic [7:0]  cur_session = 8'd7;
    logic [3:0]  cur_qlimit = 4'd8;
    logic [4:0]  seen_gen = 0;
    logic [39:0] seen_frame = 0;
    int          sent_total = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    idempotent_order_send_queue u_dut (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_stall,
        .i_mode(req.mode), .i_session(req.sess), .i_req_id(req.id), .i_quantity(req.qty),
        .i_verdict(req.ver), .i_evidence_kind(req.kind), .i_link_generation(req.gen),
        .i_allowance(req.allow), .i_transport_fatal(req.fatal),
        .o_out_valid, .i_out_stall, .o_status, .o_frozen, .o_generation_now,
        .o_queue_count, .o_front_phase, .o_front_offset, .o_sent_count, .o_frame_bytes,
        .o_result_valid, .o_result_id, .o_result_quantity, .o_result_verdict
    );

    order_queue_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall),
        .i_mode(req.mode), .i_session(req.sess), .i_req_id(req.id), .i_quantity(req.qty),
        .i_verdict(req.ver), .i_evidence_kind(req.kind), .i_link_generation(req.gen),
        .i_allowance(req.allow), .i_transport_fatal(req.fatal),
        .i_out_valid(o_out_valid), .i_out_stall, .i_status(o_status), .i_frozen(o_frozen),
        .i_generation_now(o_generation_now), .i_queue_count(o_queue_count),
        .i_front_phase(o_front_phase), .i_front_offset(o_front_offset),
        .i_sent_count(o_sent_count), .i_frame_bytes(o_frame_bytes),
        .i_result_valid(o_result_valid), .i_result_id(o_result_id),
        .i_result_quantity(o_result_quantity), .i_result_verdict(o_result_verdict),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked),
        .o_receipts(receipts)
    );

    // receiver stalls at random except during calm stretches
    always @(negedge i_clk)
        i_out_stall <= !calm && i_rst_n && ($urandom_range(99) < 14);

    always @(posedge i_clk)
        if (o_out_valid && !i_out_stall) begin
            seen_gen   <= o_generation_now;
            seen_frame <= o_frame_bytes;
        end

    function automatic t_request mk(logic [2:0] m, logic [7:0] s, logic [4:0] id,
                                    logic [3:0] q, logic [1:0] v, logic [1:0] k,
                                    logic [4:0] g, logic [2:0] a, logic f);
        return '{mode: m, sess: s, id: id, qty: q, ver: v, kind: k, gen: g, allow: a, fatal: f};
    endfunction

    // mostly well-formed traffic aimed at the live front and generation
    function automatic t_request random_request();
        t_request r;
        int pick;
        r = 33'({$urandom, $urandom});
        if ($urandom_range(99) < 4) begin
            case ($urandom_range(4))
                0: r.mode = M_ENQUEUE;
                1: r.mode = M_DISCON;
                2: r.mode = M_PUMP;
                3: r.mode = M_POP;
                default: r.mode = 3'd7;
            endcase
            return r;
        end
        r.sess  = cur_session;
        r.gen   = seen_gen;
        r.id    = seen_frame[20:16];
        r.qty   = seen_frame[11:8];
        r.ver   = 2'($urandom_range(1));
        r.kind  = ($urandom_range(9) == 0) ? 2'd1 : ($urandom_range(1) ? 2'd0 : 2'd2);
        r.fatal = ($urandom_range(99) < 4);
        pick = $urandom_range(99);
        if (pick < 6) r.mode = M_CONNECT;
        else if (pick < 26) begin
            r.mode = M_ENQUEUE;
            r.id   = 5'($urandom_range(ID_COUNT, 1));
            r.qty  = 4'($urandom_range(cur_qlimit, 1));
        end else if (pick < 29) r.mode = M_DISCON;
        else if (pick < 58) r.mode = M_PUMP;
        else if (pick < 76) r.mode = M_ACK;
        else if (pick < 86) r.mode = M_RESOLVE;
        else r.mode = M_POP;
        return r;
    endfunction

    // valid is left high after a request; the next send or drain drops or reloads it
    task automatic send(t_request r);
        while (!calm && $urandom_range(99) < 14) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        req <= r;
        i_in_valid <= 1;
        #1;
        while (o_in_stall) @(negedge i_clk) #1;
        @(negedge i_clk);
        sent_total++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        #1;
        while (!o_cfg_ready) @(negedge i_clk) #1;
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
        if (idx == CFG_SESSION) cur_session = val;
        if (idx == CFG_QLIMIT) cur_qlimit = val[3:0];
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        write_reg(CFG_SESSION, 8'hFF);
        write_reg(CFG_QLIMIT, 8'd15);
        write_reg(CFG_GLIMIT, 8'd31);
        write_reg(2'd3, 8'hAA);

        send(mk(3'd7, 8'hFF, 5'd31, 4'd15, 2'd3, 2'd3, 5'd31, 3'd7, 1'b1));
        send(mk(M_PUMP, 8'hFF, 5'd1, 4'd1, 2'd0, 2'd0, 5'd0, 3'd7, 1'b0));
        send(mk(M_DISCON, 8'hFF, 5'd1, 4'd1, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_CONNECT, 8'hFF, 5'd0, 4'd0, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_CONNECT, 8'hFF, 5'd0, 4'd0, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd0, 4'd3, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd17, 4'd3, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd5, 4'd0, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd1, 4'd15, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd1, 4'd2, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd16, 4'd1, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd2, 4'd4, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd3, 4'd5, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd4, 4'd6, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_ACK, 8'hFF, 5'd1, 4'd15, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_PUMP, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd1, 3'd0, 1'b0));
        send(mk(M_PUMP, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd1, 3'd2, 1'b0));
        send(mk(M_PUMP, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd1, 3'd7, 1'b1));
        send(mk(M_RESOLVE, 8'hFF, 5'd1, 4'd15, 2'd0, 2'd2, 5'd1, 3'd0, 1'b0));
        send(mk(M_CONNECT, 8'hFF, 5'd0, 4'd0, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_RESOLVE, 8'hFF, 5'd1, 4'd15, 2'd0, 2'd1, 5'd2, 3'd0, 1'b0));
        send(mk(M_RESOLVE, 8'hFF, 5'd1, 4'd15, 2'd0, 2'd2, 5'd2, 3'd0, 1'b0));
        send(mk(M_PUMP, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd2, 3'd7, 1'b0));
        send(mk(M_ACK, 8'hFF, 5'd1, 4'd15, 2'd1, 2'd0, 5'd2, 3'd0, 1'b0));
        send(mk(M_ACK, 8'hFF, 5'd1, 4'd15, 2'd1, 2'd0, 5'd2, 3'd0, 1'b0));
        send(mk(M_POP, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_ACK, 8'hFF, 5'd16, 4'd1, 2'd0, 2'd0, 5'd9, 3'd0, 1'b0));
        send(mk(M_PUMP, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd2, 3'd3, 1'b0));
        send(mk(M_DISCON, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd2, 3'd0, 1'b0));
        send(mk(M_CONNECT, 8'hFF, 5'd0, 4'd0, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_RESOLVE, 8'hFF, 5'd16, 4'd1, 2'd0, 2'd0, 5'd3, 3'd0, 1'b0));
        send(mk(M_POP, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        drain();

        write_reg(CFG_SESSION, 8'h5A);
        write_reg(CFG_QLIMIT, 8'd8);
        for (int n = 0; n < 900; n++) begin
            calm = (n >= 300 && n < 450);
            send(random_request());
        end
        calm = 0;
        drain();

        write_reg(CFG_SESSION, 8'h00);
        write_reg(CFG_QLIMIT, 8'd1);
        for (int n = 0; n < 900; n++) begin
            if (n == 400) drain();
            send(random_request());
        end
        drain();

        // generation exhaustion freezes the block
        send(mk(M_DISCON, 8'h00, 5'd0, 4'd0, 2'd0, 2'd0, seen_gen, 3'd0, 1'b0));
        drain();
        write_reg(CFG_GLIMIT, 8'd1);
        send(mk(M_CONNECT, cur_session, 5'd0, 4'd0, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_ENQUEUE, 8'h00, 5'd9, 4'd1, 2'd0, 2'd0, 5'd0, 3'd0, 1'b0));
        send(mk(M_ACK, cur_session, 5'd9, 4'd1, 2'd0, 2'd0, seen_gen, 3'd0, 1'b0));
        drain();

        $display("requests sent: %0d, results checked: %0d, receipts popped: %0d",
                 sent_total, checked, receipts);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
